// ===== hdl/sssp_pkg.sv =====
`timescale 1ns / 1ps
package sssp_pkg;
  localparam int unsigned DIST_W = 22;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned MAX_NODES = 64;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic CFG_SOURCE_NODE = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;
endpackage

// ===== hdl/shortest_path_single_source_top.sv =====
`timescale 1ns / 1ps
// Single-source shortest path engine. Edge items arrive on the input
// channel (valid/ready) and are written into an edge memory, one per cycle.
// The item with last_edge set starts a search from source_node over nodes
// 0 to node_count-1 (0 counts as 1, above 64 as 64); the input channel is held off
// until the search is over and the last result item has been issued.
// The search finalizes one node per pass. A pass scans all nodes in use
// and then walks every stored edge through the edge and distance memory
// read ports. Afterward one result item per node is sent in node order;
// last_node marks the final one. A stalled receiver simply holds the
// result register and the engine waits.
// The configuration channel writes source_node (index 0) and node_count
// (index 1) and is always ready. Reset empties the edge store and sets
// source_node to 0 and node_count to 64.
module shortest_path_single_source_top import sssp_pkg::*; #(
  parameter int MAX_EDGES = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [5:0]           from_node,
  input  logic [5:0]           to_node,
  input  logic [WEIGHT_W-1:0]  edge_weight,
  input  logic                 last_edge,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [5:0]           node_index,
  output logic                 reached,
  output logic [DIST_W-1:0]    distance,
  output logic [5:0]           predecessor,
  output logic                 last_node,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data
);
  localparam int EDGE_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int NODE_W = 6;

  logic [5:0] source_node;
  logic [6:0] node_count;
  logic ewr_en, start, back_idle;
  logic [EDGE_W-1:0] ewr_addr;
  logic [2*NODE_W+WEIGHT_W-1:0] ewr_data;
  logic [EDGE_W:0] start_count;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      source_node <= '0;
      node_count <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SOURCE_NODE: source_node <= cfg_data[5:0];
        CFG_NODE_COUNT: node_count <= cfg_data;
        default: ;
      endcase
    end
  end

  sssp_front #(.NODE_W(NODE_W), .EDGE_W(EDGE_W), .MAX_EDGES(MAX_EDGES)) u_front (
    .clk, .rst, .valid(in_valid), .ready(in_ready), .from_node, .to_node,
    .edge_weight, .last_edge, .ewr_en, .ewr_addr, .ewr_data, .start,
    .start_count, .back_idle
  );

  sssp_back #(.NODE_W(NODE_W), .EDGE_W(EDGE_W), .MAX_EDGES(MAX_EDGES)) u_back (
    .clk, .rst, .ewr_en, .ewr_addr, .ewr_data, .start, .start_count,
    .src(source_node), .ncount(node_count), .back_idle, .out_valid, .out_ready,
    .node_index, .reached, .distance, .predecessor, .last_node
  );
endmodule

// ===== hdl/sssp_front.sv =====
`timescale 1ns / 1ps
module sssp_front import sssp_pkg::*; #(
  parameter int NODE_W = 6,
  parameter int EDGE_W = 9,
  parameter int MAX_EDGES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                ready,
  input  logic [NODE_W-1:0]   from_node,
  input  logic [NODE_W-1:0]   to_node,
  input  logic [WEIGHT_W-1:0] edge_weight,
  input  logic                last_edge,
  output logic                ewr_en,
  output logic [EDGE_W-1:0]   ewr_addr,
  output logic [2*NODE_W+WEIGHT_W-1:0] ewr_data,
  output logic                start,
  output logic [EDGE_W:0]     start_count,
  input  logic                back_idle
);
  logic [EDGE_W:0] edges_loaded;
  logic busy;
  logic acc;

  assign ready = !busy;
  assign acc = valid && ready;
  assign ewr_en = acc && (edges_loaded < (EDGE_W+1)'(MAX_EDGES));
  assign ewr_addr = edges_loaded[EDGE_W-1:0];
  assign ewr_data = {from_node, to_node, edge_weight};

  always_ff @(posedge clk) begin
    if (rst) begin
      edges_loaded <= '0;
      busy <= 1'b0;
      start <= 1'b0;
      start_count <= '0;
    end else begin
      start <= 1'b0;
      if (acc) begin
        if (last_edge) begin
          start <= 1'b1;
          start_count <= edges_loaded + (EDGE_W+1)'(ewr_en);
          edges_loaded <= '0;
          busy <= 1'b1;
        end else if (ewr_en) begin
          edges_loaded <= edges_loaded + 1'b1;
        end
      end else if (busy && !start && back_idle) begin
        busy <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    edges_loaded <= (EDGE_W+1)'(MAX_EDGES)) else $error("edge count overflow");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> busy) else $error("start while not busy");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    start |-> edges_loaded == '0) else $error("edge count not cleared");
`endif
endmodule

// ===== hdl/sssp_back.sv =====
`timescale 1ns / 1ps
module sssp_back import sssp_pkg::*; #(
  parameter int NODE_W = 6,
  parameter int EDGE_W = 9,
  parameter int MAX_EDGES = 512
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                ewr_en,
  input  logic [EDGE_W-1:0]   ewr_addr,
  input  logic [2*NODE_W+WEIGHT_W-1:0] ewr_data,
  input  logic                start,
  input  logic [EDGE_W:0]     start_count,
  input  logic [NODE_W-1:0]   src,
  input  logic [NODE_W:0]     ncount,
  output logic                back_idle,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NODE_W-1:0]   node_index,
  output logic                reached,
  output logic [DIST_W-1:0]   distance,
  output logic [NODE_W-1:0]   predecessor,
  output logic                last_node
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_INIT = 8'b00000010, S_SCAN = 8'b00000100,
    S_EREQ = 8'b00001000, S_ERD = 8'b00010000, S_EDGE = 8'b00100000,
    S_OREQ = 8'b01000000, S_OUT = 8'b10000000
  } state_t;
  localparam int EW = 2*NODE_W+WEIGHT_W;

  state_t state;
  logic [EW-1:0] emem [MAX_EDGES];
  logic [EW-1:0] erd;
  logic [DIST_W-1:0] dmem [MAX_NODES];
  logic [NODE_W-1:0] pmem [MAX_NODES];
  logic [DIST_W-1:0] drd;
  logic [NODE_W-1:0] prd;
  logic [MAX_NODES-1:0] fin, rch;
  logic [EDGE_W:0] ecount, ek;
  logic [NODE_W:0] n, ni;
  logic [NODE_W-1:0] u, cur;
  logic have_u;
  logic [DIST_W-1:0] du, best;
  logic [NODE_W-1:0] rd_addr;
  logic dwr;
  logic [NODE_W-1:0] dwr_addr;
  logic [DIST_W-1:0] dwr_d;
  logic [NODE_W-1:0] dwr_p;
  logic [DIST_W:0] sum;
  logic [DIST_W-1:0] cand;
  logic [NODE_W-1:0] e_from, e_to;
  logic [WEIGHT_W-1:0] e_w;
  logic scan_ok;
  logic pend;

  always_ff @(posedge clk) begin
    if (ewr_en) emem[ewr_addr] <= ewr_data;
    erd <= emem[ek[EDGE_W-1:0]];
  end
  always_ff @(posedge clk) begin
    if (dwr) begin
      dmem[dwr_addr] <= dwr_d;
      pmem[dwr_addr] <= dwr_p;
    end
    drd <= dmem[rd_addr];
    prd <= pmem[rd_addr];
  end

  assign {e_from, e_to, e_w} = erd;
  assign sum = {1'b0, du} + (DIST_W+1)'(e_w);
  assign cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  assign back_idle = (state == S_IDLE);
  assign scan_ok = pend && rch[cur] && !fin[cur];

  always_comb begin
    rd_addr = ni[NODE_W-1:0];
    if (state == S_ERD || state == S_EDGE) rd_addr = e_to;
    dwr = 1'b0;
    dwr_addr = e_to;
    dwr_d = cand;
    dwr_p = u;
    if (state == S_INIT) begin
      dwr = 1'b1;
      dwr_addr = src;
      dwr_d = '0;
      dwr_p = src;
    end else if (state == S_EDGE && pend && e_from == u &&
                 {1'b0, e_to} < n && !fin[e_to] &&
                 (!rch[e_to] || cand < drd || (cand == drd && u < prd))) begin
      dwr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      fin <= '0;
      rch <= '0;
      pend <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            ecount <= start_count;
            n <= (ncount == '0) ? (NODE_W+1)'(1) :
                 ((ncount > (NODE_W+1)'(MAX_NODES)) ? (NODE_W+1)'(MAX_NODES) : ncount);
            fin <= '0;
            rch <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          if ({1'b0, src} < n) rch[src] <= 1'b1;
          ni <= '0;
          have_u <= 1'b0;
          pend <= 1'b0;
          state <= ({1'b0, src} < n) ? S_SCAN : S_OREQ;
        end
        S_SCAN: begin
          if (pend) begin
            if (scan_ok && (!have_u || drd < best)) begin
              have_u <= 1'b1;
              best <= drd;
              u <= cur;
            end
          end
          if (ni < n) begin
            cur <= ni[NODE_W-1:0];
            ni <= ni + 1'b1;
            pend <= 1'b1;
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            if (have_u) begin
              fin[u] <= 1'b1;
              du <= best;
              ek <= '0;
              state <= S_EREQ;
            end else begin
              ni <= '0;
              state <= S_OREQ;
            end
          end
        end
        S_EREQ: begin
          pend <= (ek < ecount);
          state <= S_ERD;
        end
        S_ERD: begin
          state <= S_EDGE;
        end
        S_EDGE: begin
          if (dwr) rch[e_to] <= 1'b1;
          if (pend) begin
            ek <= ek + 1'b1;
            state <= S_EREQ;
          end else begin
            ni <= '0;
            have_u <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_OREQ: begin
          if (!out_valid || out_ready) begin
            cur <= ni[NODE_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          node_index <= cur;
          reached <= rch[cur];
          distance <= rch[cur] ? drd : DIST_MAX;
          predecessor <= rch[cur] ? prd : '0;
          last_node <= (ni + 1'b1 == n);
          if (ni + 1'b1 == n) begin
            state <= S_IDLE;
          end else begin
            ni <= ni + 1'b1;
            state <= S_OREQ;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fin_reached: assert property (@(posedge clk) disable iff (rst)
    (fin & ~rch) == '0) else $error("finalized node not reached");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(node_index))
    else $error("result dropped");
  a_unreached: assert property (@(posedge clk) disable iff (rst)
    out_valid && !reached |-> distance == DIST_MAX) else $error("bad unreached");
`endif
endmodule

// ===== test/tb_shortest_path_single_source_top.sv =====
`timescale 1ns / 1ps
module tb_shortest_path_single_source_top;
  import sssp_pkg::*;

  localparam int NODE_LIMIT = 64;
  localparam int EDGE_LIMIT = 512;

  typedef struct {
    logic [5:0]        node_index;
    logic              reached;
    logic [DIST_W-1:0] distance;
    logic [5:0]        predecessor;
    logic              last_node;
  } node_report_t;

  class path_scoreboard;
    logic [5:0]          edge_from [EDGE_LIMIT];
    logic [5:0]          edge_to [EDGE_LIMIT];
    logic [WEIGHT_W-1:0] edge_len [EDGE_LIMIT];
    int                  edge_count;
    logic [5:0]          source;
    logic [6:0]          count;
    node_report_t        pending_reports [$];
    int                  errors;

    function new();
      edge_count = 0;
      source = 0;
      count = 64;
      errors = 0;
    endfunction

    function void write_register(logic idx, logic [6:0] data);
      if (idx == CFG_SOURCE_NODE) source = data[5:0];
      else count = data;
    endfunction

    function void solve_paths();
      int n, u, k, v;
      logic [DIST_W-1:0] best_dist [NODE_LIMIT];
      logic [5:0] pred [NODE_LIMIT];
      bit done [NODE_LIMIT];
      bit seen [NODE_LIMIT];
      int unsigned cand;
      node_report_t r;
      n = (count == 0) ? 1 : (count > NODE_LIMIT) ? NODE_LIMIT : count;
      for (int i = 0; i < NODE_LIMIT; i++) begin
        best_dist[i] = DIST_MAX;
        pred[i] = 0;
        done[i] = 0;
        seen[i] = 0;
      end
      if (source < n) begin
        best_dist[source] = 0;
        pred[source] = source;
        seen[source] = 1;
        forever begin
          u = n;
          for (int i = 0; i < n; i++)
            if (seen[i] && !done[i] && (u == n || best_dist[i] < best_dist[u])) u = i;
          if (u == n) break;
          done[u] = 1;
          for (k = 0; k < edge_count; k++) begin
            v = edge_to[k];
            if (edge_from[k] != u || v >= n || done[v]) continue;
            cand = best_dist[u] + edge_len[k];
            if (cand > DIST_MAX) cand = DIST_MAX;
            if (!seen[v] || cand < best_dist[v] || (cand == best_dist[v] && u < pred[v])) begin
              best_dist[v] = cand[DIST_W-1:0];
              pred[v] = 6'(u);
              seen[v] = 1;
            end
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        r.node_index = 6'(i);
        r.reached = seen[i];
        r.distance = seen[i] ? best_dist[i] : DIST_MAX;
        r.predecessor = seen[i] ? pred[i] : 6'd0;
        r.last_node = (i + 1 == n);
        pending_reports = {pending_reports, r};
      end
      edge_count = 0;
    endfunction

    function void note_edge(logic [5:0] f, logic [5:0] t, logic [WEIGHT_W-1:0] w, logic l);
      if (edge_count < EDGE_LIMIT) begin
        edge_from[edge_count] = f;
        edge_to[edge_count] = t;
        edge_len[edge_count] = w;
        edge_count++;
      end
      if (l) solve_paths();
    endfunction

    function void check_report(node_report_t got);
      node_report_t exp;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result for node %0d", $time, got.node_index);
        errors++;
        return;
      end
      exp = pending_reports.pop_front();
      if (got.node_index !== exp.node_index) begin
        $display("%0t: node_index expected %0d actual %0d", $time, exp.node_index,
                 got.node_index);
        errors++;
      end
      if (got.reached !== exp.reached) begin
        $display("%0t: node %0d reached expected %0d actual %0d", $time, exp.node_index,
                 exp.reached, got.reached);
        errors++;
      end
      if (got.distance !== exp.distance) begin
        $display("%0t: node %0d distance expected %0d actual %0d", $time, exp.node_index,
                 exp.distance, got.distance);
        errors++;
      end
      if (got.predecessor !== exp.predecessor) begin
        $display("%0t: node %0d predecessor expected %0d actual %0d", $time,
                 exp.node_index, exp.predecessor, got.predecessor);
        errors++;
      end
      if (got.last_node !== exp.last_node) begin
        $display("%0t: node %0d last_node expected %0d actual %0d", $time, exp.node_index,
                 exp.last_node, got.last_node);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [5:0] from_node;
  logic [5:0] to_node;
  logic [WEIGHT_W-1:0] edge_weight;
  logic last_edge;
  logic out_valid;
  logic out_ready;
  logic [5:0] node_index;
  logic reached;
  logic [DIST_W-1:0] distance;
  logic [5:0] predecessor;
  logic last_node;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [6:0] cfg_data;

  path_scoreboard board;
  bit steady;
  int edges_sent;

  shortest_path_single_source_top DUT (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("[shortest_path_single_source_top] ERROR");
    $finish;
  end

  initial begin
    node_report_t got;
    int stall;
    out_ready = 0;
    @(negedge rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!(out_valid && out_ready));
      got.node_index = node_index;
      got.reached = reached;
      got.distance = distance;
      got.predecessor = predecessor;
      got.last_node = last_node;
      board.check_report(got);
    end
  end

  task automatic send_edge(logic [5:0] f, logic [5:0] t, logic [WEIGHT_W-1:0] w, logic l);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    from_node <= f;
    to_node <= t;
    edge_weight <= w;
    last_edge <= l;
    do @(posedge clk); while (!in_ready);
    board.note_edge(f, t, w, l);
    edges_sent++;
  endtask

  task automatic settle();
    in_valid <= 0;
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(idx, data);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_graph(int n_edges, int hi);
    logic [WEIGHT_W-1:0] w;
    for (int k = 0; k < n_edges; k++) begin
      w = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                      : 16'($urandom_range(0, 20));
      send_edge(6'($urandom_range(0, hi)), 6'($urandom_range(0, hi)), w,
                k == n_edges - 1);
    end
  endtask

  initial begin
    int n, r;
    board = new();
    steady = 0;
    edges_sent = 0;
    rst <= 1;
    in_valid <= 0;
    from_node <= 0;
    to_node <= 0;
    edge_weight <= 0;
    last_edge <= 0;
    cfg_valid <= 0;
    cfg_index <= CFG_SOURCE_NODE;
    cfg_data <= 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    write_cfg(CFG_NODE_COUNT, 7'd4);
    send_edge(0, 1, 0, 0);
    send_edge(0, 2, 16'hFFFF, 0);
    send_edge(1, 2, 16'hFFFF, 0);
    send_edge(2, 2, 3, 0);
    send_edge(1, 0, 0, 0);
    send_edge(5, 3, 1, 0);
    send_edge(2, 3, 7, 1);
    settle();
    write_cfg(CFG_SOURCE_NODE, 7'd63);
    write_cfg(CFG_NODE_COUNT, 7'd64);
    send_edge(63, 0, 16'hFFFF, 0);
    send_edge(0, 63, 1, 0);
    send_edge(0, 42, 16'h5555, 0);
    send_edge(42, 21, 16'hAAAA, 1);
    settle();
    write_cfg(CFG_SOURCE_NODE, 7'd0);
    write_cfg(CFG_NODE_COUNT, 7'd0);
    send_edge(0, 0, 9, 1);
    settle();
    write_cfg(CFG_SOURCE_NODE, 7'd10);
    write_cfg(CFG_NODE_COUNT, 7'd127);
    send_edge(10, 11, 5, 0);
    send_edge(11, 12, 5, 1);
    settle();
    write_cfg(CFG_SOURCE_NODE, 7'd5);
    write_cfg(CFG_NODE_COUNT, 7'd3);
    send_edge(5, 0, 1, 0);
    send_edge(0, 1, 1, 1);
    settle();

    while (edges_sent < 260) begin
      steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      n = (r == 0) ? 0 : (r == 1) ? 64 : (r == 2) ? $urandom_range(65, 127)
                                                  : $urandom_range(1, 16);
      write_cfg(CFG_NODE_COUNT, 7'(n));
      n = (n == 0) ? 1 : (n > 64) ? 64 : n;
      if ($urandom_range(0, 7) == 0) write_cfg(CFG_SOURCE_NODE, 7'($urandom_range(0, 63)));
      else write_cfg(CFG_SOURCE_NODE, 7'($urandom_range(0, n - 1)));
      random_graph($urandom_range(1, (2 * n > 40) ? 40 : 2 * n),
                   ($urandom_range(0, 5) == 0) ? 63 : n - 1);
      settle();
    end

    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("[shortest_path_single_source_top] OK");
    end else begin
      $display("[shortest_path_single_source_top] ERROR");
    end
    $finish;
  end
endmodule
